// ===== src/sitda_pkg.sv =====
package sitda_pkg;

  localparam int unsigned BinW = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW = 4 * NumDigits;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NumStages = BinW / StepsPerStage;
  localparam int unsigned IdxW = $clog2(NumDigits);
  localparam int unsigned CharW = 6;
  localparam int unsigned OutTdataW = 8;

  localparam logic [CharW-1:0] AsciiZero = 6'd48;
  localparam logic [CharW-1:0] AsciiMinus = 6'd45;

  // conversion word carried down the pipeline
  typedef struct packed {
    logic            neg;
    logic [BcdW-1:0] bcd;
    logic [BinW-1:0] bin;
  } conv_t;

  // one shift-add-3 step: adjust every digit, then move one binary bit in
  function automatic conv_t dabble_step(conv_t c);
    conv_t           r;
    logic [BcdW-1:0] adj;
    adj = c.bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    r.neg = c.neg;
    r.bcd = {adj[BcdW-2:0], c.bin[BinW-1]};
    r.bin = {c.bin[BinW-2:0], 1'b0};
    return r;
  endfunction

endpackage

// ===== src/sitda_dabble_stage.sv =====
module sitda_dabble_stage
  import sitda_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  conv_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output conv_t out_data_o
);

  logic  valid_q;
  conv_t data_q, data_d;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d = in_data_i;
    for (int s = 0; s < StepsPerStage; s++) begin
      data_d = dabble_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/sitda_serializer.sv =====
module sitda_serializer
  import sitda_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  conv_t                in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CharW-1:0]     out_char_o,
  output logic                 out_last_o
);

  logic            busy_q;
  logic            sign_q;
  logic [IdxW-1:0] idx_q, idx_d, top_idx;
  logic [BcdW-1:0] bcd_q;
  logic [3:0]      cur_digit;
  logic            hs_out, load;

  // highest nonzero digit, or digit zero for a zero value
  always_comb begin
    top_idx = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (in_data_i.bcd[4*d +: 4] != 4'd0) begin
        top_idx = IdxW'(d);
      end
    end
  end

  assign cur_digit   = bcd_q[{idx_q, 2'b00} +: 4];
  assign out_valid_o = busy_q;
  assign out_char_o  = sign_q ? AsciiMinus : (AsciiZero + CharW'(cur_digit));
  assign out_last_o  = !sign_q && (idx_q == '0);
  assign hs_out      = busy_q && out_ready_i;
  assign in_ready_o  = !busy_q || (out_ready_i && out_last_o);
  assign load        = in_valid_i && in_ready_o;

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = top_idx;
    end else if (hs_out && !sign_q && !out_last_o) begin
      idx_d = idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        busy_q <= 1'b1;
        sign_q <= in_data_i.neg;
      end else if (hs_out) begin
        if (sign_q) begin
          sign_q <= 1'b0;
        end else if (out_last_o) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q <= in_data_i.bcd;
    end
  end

endmodule

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// signed 32-bit integer to decimal ascii text
//
// slave stream: one request per integer on s_axis_tdata_i (two's complement).
// master stream: its decimal text, one character per transfer, most
// significant first, tlast on the final character. a negative value starts
// with '-', zero gives a single '0', leading zeros are dropped, so a run is
// 1 to 11 characters; -2147483648 gives all eleven.
//
// an input register takes the magnitude, eight registered stages of four
// shift-add-3 steps each turn it into ten bcd digits, and a serializer
// sends them out. the serializer emits one character per cycle while the
// receiver is ready, and it can take the next item as the last character
// of the current one goes out; the pipeline ahead of it keeps up to nine
// more values in flight.
//
// reset clears all valid bits; nothing is stored between items. when the
// receiver stalls, the current character holds and the pipeline fills up
// before s_axis_tready_o drops; nothing is lost or repeated.
module signed_int_to_decimal_ascii_top
  import sitda_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [BinW-1:0]      s_axis_tdata_i,   // [31:0] value
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o,   // [5:0] char_code, [7:6] zero
  output logic                 m_axis_tlast_o    // last
);

  logic  in_valid_q;
  conv_t in_data_q;

  logic  st_valid [NumStages+1];
  logic  st_ready [NumStages+1];
  conv_t st_data  [NumStages+1];

  logic [CharW-1:0] char_code;

  assign s_axis_tready_o = !in_valid_q || st_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // take the magnitude up front; the most negative value wraps to 2^31
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q.neg <= s_axis_tdata_i[BinW-1];
      in_data_q.bcd <= '0;
      in_data_q.bin <= s_axis_tdata_i[BinW-1] ? (~s_axis_tdata_i + 1'b1) : s_axis_tdata_i;
    end
  end

  assign st_valid[0] = in_valid_q;
  assign st_data[0]  = in_data_q;

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    sitda_dabble_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (st_valid[g]),
      .in_ready_o  (st_ready[g]),
      .in_data_i   (st_data[g]),
      .out_valid_o (st_valid[g+1]),
      .out_ready_i (st_ready[g+1]),
      .out_data_o  (st_data[g+1])
    );
  end

  sitda_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (st_valid[NumStages]),
    .in_ready_o  (st_ready[NumStages]),
    .in_data_i   (st_data[NumStages]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (char_code),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(OutTdataW - CharW){1'b0}}, char_code};

endmodule

// ===== src/sitda_checker.sv =====
module sitda_checker
  import sitda_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o,
  input logic                 m_axis_tlast_o
);

  logic hs_out, is_minus;

  assign hs_out   = m_axis_tvalid_o && m_axis_tready_i;
  assign is_minus = m_axis_tdata_o == OutTdataW'(AsciiMinus);

  // a stalled character holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled character changed");

  // only '-' or a digit ever leaves
  a_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> is_minus ||
      (m_axis_tdata_o >= OutTdataW'(AsciiZero) && m_axis_tdata_o <= OutTdataW'(AsciiZero + 6'd9)))
    else $error("character out of range");

  // a run never ends on the sign
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && is_minus |-> !m_axis_tlast_o)
    else $error("run ended on minus sign");

  // a run is sent without gaps, and the sign is followed by a digit
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs_out && !m_axis_tlast_o |=> m_axis_tvalid_o && !is_minus)
    else $error("gap or repeated sign inside a run");

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (.*);
